// ===== src/are_pkg.sv =====
// Shared constants, types and helpers for the angular rate estimator.
// Used by every module of the block; depends on nothing else.
`default_nettype none
package are_pkg;

    // Field widths.
    localparam int ANGLE_W = 19;
    localparam int TIME_W  = 32;
    localparam int RATE_W  = 32;
    localparam int TAU_W   = 20;
    localparam int MING_W  = 20;
    localparam int MAXG_W  = 24;
    localparam int DT_W    = 24;   // a step in the rate path is below max_gap_us

    // Alpha table.
    localparam int ALPHA_TABLE_DEPTH_DEF = 256;
    localparam int ALPHA_W   = 16;
    localparam int ALPHA_ONE = 65536;

    // Shared multiplier and divider widths.
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 21;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int NUM_W   = 40;
    localparam int DEN_W   = 24;

    // Angle constants in Q16 radians.
    localparam logic signed [19:0] PI_Q16     = 20'sd205887;
    localparam logic signed [19:0] TWO_PI_Q16 = 20'sd411775;
    localparam logic signed [20:0] US_PER_S   = 21'sd1000000;

    // Register map, word index from paddr[3:2].
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_TAU  = 2'd0;
    localparam logic [1:0] REG_MING = 2'd1;
    localparam logic [1:0] REG_MAXG = 2'd2;

    localparam logic [TAU_W-1:0]  TAU_RST  = 20'd20000;
    localparam logic [MING_W-1:0] MING_RST = 20'd100;
    localparam logic [MAXG_W-1:0] MAXG_RST = 24'd500000;

    // Wrap an angle difference into [-pi, pi]; one correction always suffices.
    function automatic logic signed [ANGLE_W-1:0] wrap_q16(input logic signed [19:0] d);
        logic signed [19:0] w;
        begin
            w = d;
            if (d > PI_Q16)
            begin
                w = d - TWO_PI_Q16;
            end
            else if (d < -PI_Q16)
            begin
                w = d + TWO_PI_Q16;
            end
            wrap_q16 = w[ANGLE_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/are_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on are_pkg for operand widths.
`default_nettype none
module are_mul
(
    input  wire logic                                  clk,
    input  wire logic signed [are_pkg::MUL_A_W-1:0]    a,
    input  wire logic signed [are_pkg::MUL_B_W-1:0]    b,
    output      logic signed [are_pkg::MUL_P_W-1:0]    p
);

    logic signed [are_pkg::MUL_P_W-1:0] p_reg;

    // One product per cycle, available the cycle after the operands.
    always_ff @(posedge clk)
    begin
        p_reg <= are_pkg::MUL_P_W'(a) * are_pkg::MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule
`default_nettype wire

// ===== src/are_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the rate and index paths.
// Depends on are_pkg for operand widths.
`default_nettype none
module are_div
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [are_pkg::NUM_W-1:0]     num,
    input  wire logic [are_pkg::DEN_W-1:0]     den,
    output      logic                          done,
    output      logic [are_pkg::NUM_W-1:0]     quot
);

    localparam int CNT_W = $clog2(are_pkg::NUM_W + 1);

    logic [are_pkg::DEN_W:0]   rem_reg, rem_next;
    logic [are_pkg::NUM_W-1:0] sh_reg, sh_next;
    logic [are_pkg::DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [are_pkg::DEN_W:0]   trial;

    // One compare and subtract step per cycle.
    always_comb
    begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[are_pkg::DEN_W-1:0], sh_reg[are_pkg::NUM_W-1]};
        if (start)
        begin
            rem_next  = '0;
            sh_next   = num;
            den_next  = den;
            cnt_next  = CNT_W'(are_pkg::NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                sh_next  = {sh_reg[are_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                sh_next  = {sh_reg[are_pkg::NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = sh_reg;

endmodule
`default_nettype wire

// ===== src/angular_rate_estimator.sv =====
// Angular rate estimator top level: register port, sequencer, alpha table and state.
// Depends on are_pkg, are_mul and are_div.
`default_nettype none
// Estimates smoothed yaw and pitch rates (Q16 rad/s) from angle samples with
// microsecond timestamps, one result word per input word. A sample that only
// stores state or clears the rates passes from S_CHECK straight to S_DONE. A
// rate update runs two raw-rate divisions on the shared bit-serial divider (40
// steps each); once an estimate exists, samples also divide for the alpha table
// index and blend through the shared multiplier. The block takes no new word
// while a sample is in work; a finished result waits in an output register.
module angular_rate_estimator
#(
    parameter int ALPHA_TABLE_DEPTH = are_pkg::ALPHA_TABLE_DEPTH_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Register port.
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [are_pkg::ADDR_W-1:0]          paddr,
    input  wire logic [31:0]                         pwdata,
    output      logic [31:0]                         prdata,
    output      logic                                pready,
    // Sample input.
    input  wire logic                                in_valid,
    output      logic                                in_ready,
    input  wire logic signed [are_pkg::ANGLE_W-1:0]  yaw_angle,
    input  wire logic signed [are_pkg::ANGLE_W-1:0]  pitch_angle,
    input  wire logic [are_pkg::TIME_W-1:0]          timestamp_us,
    // Rate output.
    output      logic                                out_valid,
    input  wire logic                                out_ready,
    output      logic signed [are_pkg::RATE_W-1:0]   yaw_rate,
    output      logic signed [are_pkg::RATE_W-1:0]   pitch_rate,
    output      logic                                rate_valid,
    output      logic                                gap_reset
);

    localparam int IDX_W = $clog2(ALPHA_TABLE_DEPTH);

    typedef logic [are_pkg::ALPHA_W-1:0] alpha_rom_t [ALPHA_TABLE_DEPTH];

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_CHECK = 13'b0000000000010,
        S_RMUL  = 13'b0000000000100,
        S_RDIV  = 13'b0000000001000,
        S_RWAIT = 13'b0000000010000,
        S_IMUL  = 13'b0000000100000,
        S_IDIV  = 13'b0000001000000,
        S_IWAIT = 13'b0000010000000,
        S_BMUL0 = 13'b0000100000000,
        S_BMUL1 = 13'b0001000000000,
        S_BACC  = 13'b0010000000000,
        S_DONE  = 13'b0100000000000,
        S_ALPHA = 13'b1000000000000
    } state_t;

    // Alpha table: 1 - exp(-8*i/depth) in Q0.16, built at elaboration.
    function automatic alpha_rom_t build_rom();
        alpha_rom_t         t;
        logic [63:0]        h;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        logic [63:0]        p;
        logic [63:0]        e;
        begin
            h    = (64'd1 << 35) / 64'(ALPHA_TABLE_DEPTH);
            term = 64'd1 << 32;
            sum  = $signed(term);
            for (int k = 1; k <= 24; k++)
            begin
                term = ((term * h) >> 32) / 64'(k);
                if ((k % 2) == 1)
                begin
                    sum = sum - $signed(term);
                end
                else
                begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            r = $unsigned(sum);
            if (r > (64'd1 << 32))
            begin
                r = 64'd1 << 32;
            end
            p = 64'd1 << 32;
            for (int i = 0; i < ALPHA_TABLE_DEPTH; i++)
            begin
                if (i > 0)
                begin
                    p = (p * r + (64'd1 << 31)) >> 32;
                end
                if (p > (64'd1 << 32))
                begin
                    p = 64'd1 << 32;
                end
                e = (((64'd1 << 32) - p) + 64'd32768) >> 16;
                if (e > 64'd65535)
                begin
                    e = 64'd65535;
                end
                t[i] = e[are_pkg::ALPHA_W-1:0];
            end
            build_rom = t;
        end
    endfunction

    localparam alpha_rom_t ALPHA_ROM = build_rom();

    // Configuration registers.
    logic [are_pkg::TAU_W-1:0]  tau_reg;
    logic [are_pkg::MING_W-1:0] ming_reg;
    logic [are_pkg::MAXG_W-1:0] maxg_reg;
    logic                       cfg_wr;

    // Sample state.
    logic [are_pkg::TIME_W-1:0]         prev_time_reg;
    logic signed [are_pkg::ANGLE_W-1:0] prev_yaw_reg;
    logic signed [are_pkg::ANGLE_W-1:0] prev_pitch_reg;
    logic                               have_prev_reg;
    logic                               have_est_reg;
    logic signed [are_pkg::RATE_W-1:0]  smooth_reg [2];

    // Working registers.
    state_t                             state_reg, state_next;
    logic                               had_prev_reg;
    logic [are_pkg::TIME_W-1:0]         dt_reg;
    logic signed [are_pkg::ANGLE_W-1:0] diff_reg [2];
    logic signed [are_pkg::RATE_W-1:0]  raw_reg [2];
    logic                               axis_reg;
    logic [are_pkg::ALPHA_W:0]          alpha_reg;
    logic signed [are_pkg::MUL_P_W-1:0] acc_reg;
    logic                               cleared_reg;

    // Output word.
    logic                               out_valid_reg;
    logic signed [are_pkg::RATE_W-1:0]  yaw_out_reg;
    logic signed [are_pkg::RATE_W-1:0]  pitch_out_reg;
    logic                               rv_out_reg;
    logic                               gr_out_reg;

    // Shared units.
    logic signed [are_pkg::MUL_A_W-1:0] mul_a;
    logic signed [are_pkg::MUL_B_W-1:0] mul_b;
    logic signed [are_pkg::MUL_P_W-1:0] mul_p;
    logic                               div_start;
    logic [are_pkg::NUM_W-1:0]          div_num;
    logic [are_pkg::DEN_W-1:0]          div_den;
    logic                               div_done;
    logic [are_pkg::NUM_W-1:0]          div_quot;

    logic                               in_acc;
    logic [are_pkg::TIME_W-1:0]         dt_in;
    logic signed [are_pkg::ANGLE_W-1:0] diff_axis;
    logic [are_pkg::ANGLE_W-1:0]        mag_axis;
    logic signed [are_pkg::RATE_W-1:0]  raw_sat;
    logic [are_pkg::TAU_W-1:0]          tau_eff;
    logic [IDX_W-1:0]                   idx_sat;
    logic signed [are_pkg::MUL_P_W-1:0] blend_sum;
    logic signed [are_pkg::MUL_P_W-1:0] blend_q;
    logic signed [are_pkg::RATE_W-1:0]  blend_sat;
    logic                               axis_flag;

    are_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    are_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Register port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            are_pkg::REG_TAU:  prdata = 32'(tau_reg);
            are_pkg::REG_MING: prdata = 32'(ming_reg);
            are_pkg::REG_MAXG: prdata = 32'(maxg_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tau_reg  <= are_pkg::TAU_RST;
            ming_reg <= are_pkg::MING_RST;
            maxg_reg <= are_pkg::MAXG_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                are_pkg::REG_TAU:  tau_reg  <= pwdata[are_pkg::TAU_W-1:0];
                are_pkg::REG_MING: ming_reg <= pwdata[are_pkg::MING_W-1:0];
                are_pkg::REG_MAXG: maxg_reg <= pwdata[are_pkg::MAXG_W-1:0];
                default:           ;
            endcase
        end
    end

    // Handshakes.
    assign in_ready = (state_reg == S_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign dt_in    = timestamp_us - prev_time_reg;

    // Per-axis datapath helpers.
    assign axis_flag = axis_reg;
    assign diff_axis = diff_reg[axis_flag];
    assign mag_axis  = diff_axis[are_pkg::ANGLE_W-1] ? $unsigned(-diff_axis)
                                                     : $unsigned(diff_axis);
    assign tau_eff   = (tau_reg == '0) ? are_pkg::TAU_W'(1) : tau_reg;

    // Saturate the raw rate quotient with the sign of the angle difference.
    always_comb
    begin
        if (diff_axis[are_pkg::ANGLE_W-1])
        begin
            if (div_quot > are_pkg::NUM_W'(64'h8000_0000))
            begin
                raw_sat = 32'sh8000_0000;
            end
            else
            begin
                raw_sat = -$signed(div_quot[are_pkg::RATE_W-1:0]);
            end
        end
        else if (div_quot > are_pkg::NUM_W'(64'h7FFF_FFFF))
        begin
            raw_sat = 32'sh7FFF_FFFF;
        end
        else
        begin
            raw_sat = $signed(div_quot[are_pkg::RATE_W-1:0]);
        end
    end

    // Clamp the table index to the last entry.
    always_comb
    begin
        if (div_quot >= are_pkg::NUM_W'(ALPHA_TABLE_DEPTH))
        begin
            idx_sat = IDX_W'(ALPHA_TABLE_DEPTH - 1);
        end
        else
        begin
            idx_sat = div_quot[IDX_W-1:0];
        end
    end

    // Blend: round, floor-shift by 16, saturate.
    always_comb
    begin
        blend_sum = acc_reg + mul_p + are_pkg::MUL_P_W'(32768);
        blend_q   = blend_sum >>> 16;
        if (blend_q > are_pkg::MUL_P_W'(64'sh7FFF_FFFF))
        begin
            blend_sat = 32'sh7FFF_FFFF;
        end
        else if (blend_q < -are_pkg::MUL_P_W'(64'sh8000_0000))
        begin
            blend_sat = 32'sh8000_0000;
        end
        else
        begin
            blend_sat = blend_q[are_pkg::RATE_W-1:0];
        end
    end

    // Shared unit operands per step.
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = dt_reg[are_pkg::DEN_W-1:0];
        unique case (state_reg)
            S_RMUL:
            begin
                mul_a = are_pkg::MUL_A_W'(mag_axis);
                mul_b = are_pkg::US_PER_S;
            end
            S_RDIV:
            begin
                div_start = 1'b1;
                div_num   = are_pkg::NUM_W'(mul_p)
                          + are_pkg::NUM_W'(dt_reg[are_pkg::DEN_W-1:1]);
            end
            S_IMUL:
            begin
                mul_a = are_pkg::MUL_A_W'(dt_reg[are_pkg::DT_W-1:0]);
                mul_b = are_pkg::MUL_B_W'(ALPHA_TABLE_DEPTH);
            end
            S_IDIV:
            begin
                div_start = 1'b1;
                div_num   = are_pkg::NUM_W'(mul_p);
                div_den   = are_pkg::DEN_W'({tau_eff, 3'b000});
            end
            S_BMUL0:
            begin
                mul_a = are_pkg::MUL_A_W'(smooth_reg[axis_flag]);
                mul_b = are_pkg::MUL_B_W'(are_pkg::ALPHA_ONE)
                      - are_pkg::MUL_B_W'(alpha_reg);
            end
            S_BMUL1:
            begin
                mul_a = are_pkg::MUL_A_W'(raw_reg[axis_flag]);
                mul_b = are_pkg::MUL_B_W'(alpha_reg);
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (had_prev_reg && (dt_reg < 32'(maxg_reg)))
                begin
                    if (dt_reg > 32'(ming_reg))
                    begin
                        state_next = S_RMUL;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RMUL:  state_next = S_RDIV;
            S_RDIV:  state_next = S_RWAIT;
            S_RWAIT:
            begin
                if (div_done)
                begin
                    if (!axis_reg)
                    begin
                        state_next = S_RMUL;
                    end
                    else if (have_est_reg)
                    begin
                        state_next = S_IMUL;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_IMUL:  state_next = S_IDIV;
            S_IDIV:  state_next = S_IWAIT;
            S_IWAIT:
            begin
                if (div_done)
                begin
                    state_next = S_ALPHA;
                end
            end
            S_ALPHA: state_next = S_BMUL0;
            S_BMUL0: state_next = S_BMUL1;
            S_BMUL1: state_next = S_BACC;
            S_BACC:  state_next = axis_reg ? S_DONE : S_BMUL0;
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            have_prev_reg  <= 1'b0;
            have_est_reg   <= 1'b0;
            prev_time_reg  <= '0;
            prev_yaw_reg   <= '0;
            prev_pitch_reg <= '0;
            smooth_reg[0]  <= '0;
            smooth_reg[1]  <= '0;
            out_valid_reg  <= 1'b0;
            had_prev_reg   <= 1'b0;
            cleared_reg    <= 1'b0;
            axis_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // A new word replaces the one leaving, or fills an empty slot.
            if ((state_reg == S_DONE) && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        had_prev_reg   <= have_prev_reg;
                        have_prev_reg  <= 1'b1;
                        prev_time_reg  <= timestamp_us;
                        prev_yaw_reg   <= yaw_angle;
                        prev_pitch_reg <= pitch_angle;
                        cleared_reg    <= 1'b0;
                        axis_reg       <= 1'b0;
                    end
                end
                S_CHECK:
                begin
                    if (had_prev_reg && (dt_reg >= 32'(maxg_reg)))
                    begin
                        smooth_reg[0] <= '0;
                        smooth_reg[1] <= '0;
                        have_est_reg  <= 1'b0;
                        cleared_reg   <= 1'b1;
                    end
                end
                S_RWAIT:
                begin
                    if (div_done)
                    begin
                        axis_reg <= ~axis_reg;
                        if (axis_reg && !have_est_reg)
                        begin
                            smooth_reg[0] <= raw_reg[0];
                            smooth_reg[1] <= raw_sat;
                            have_est_reg  <= 1'b1;
                        end
                    end
                end
                S_BACC:
                begin
                    smooth_reg[axis_flag] <= blend_sat;
                    axis_reg              <= ~axis_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            dt_reg      <= dt_in;
            diff_reg[0] <= are_pkg::wrap_q16(20'(yaw_angle) - 20'(prev_yaw_reg));
            diff_reg[1] <= are_pkg::wrap_q16(20'(pitch_angle) - 20'(prev_pitch_reg));
        end
        if ((state_reg == S_RWAIT) && div_done)
        begin
            raw_reg[axis_flag] <= raw_sat;
        end
        if ((state_reg == S_IWAIT) && div_done)
        begin
            alpha_reg <= {1'b0, ALPHA_ROM[idx_sat]};
        end
        if (state_reg == S_BMUL1)
        begin
            acc_reg <= mul_p;
        end
        if ((state_reg == S_DONE) && (!out_valid_reg || out_ready))
        begin
            yaw_out_reg   <= smooth_reg[0];
            pitch_out_reg <= smooth_reg[1];
            rv_out_reg    <= have_est_reg;
            gr_out_reg    <= cleared_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign yaw_rate   = yaw_out_reg;
    assign pitch_rate = pitch_out_reg;
    assign rate_valid = rv_out_reg;
    assign gap_reset  = gr_out_reg;

endmodule
`default_nettype wire
